### src/lpkv_pkg.sv
// Package for the linear-probe key/value table: sizes, codes and the
// transaction, slot entry and memory request types. No dependencies.
`default_nettype none

package lpkv_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned KeyBytes   = 8;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned KeyW       = 64;
  localparam int unsigned AddrW      = 48;
  localparam int unsigned CountW     = 16;
  localparam int unsigned SlotOutW   = 6;
  localparam int unsigned AlignW     = 20;

  localparam logic [KeyW-1:0] KeyMask =
    (KeyBytes >= 8) ? {KeyW{1'b1}} : KeyW'((65'd1 << (KeyBytes * 8)) - 65'd1);
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  typedef enum logic [1:0] {
    OpRegister   = 2'd0,
    OpDeregister = 2'd1,
    OpLookup     = 2'd2,
    OpCheck      = 2'd3
  } op_e;

  localparam logic [1:0] StatusOk   = 2'd0;
  localparam logic [1:0] StatusMiss = 2'd1;
  localparam logic [1:0] StatusFull = 2'd2;

  typedef enum logic {
    StIdle,
    StProbe
  } state_e;

  typedef struct packed {
    logic [1:0]       operation;
    logic [KeyW-1:0]  key;
    logic [AddrW-1:0] buffer_address;
    logic [AddrW-1:0] buffer_size;
  } lpkv_req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [SlotOutW-1:0] slot_index;
    logic [AddrW-1:0]    region_base;
    logic [AlignW-1:0]   region_offset;
    logic [AddrW-1:0]    region_size;
    logic [CountW-1:0]   live_count;
  } lpkv_rsp_t;

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [AddrW-1:0] address;
    logic [AddrW-1:0] size;
  } slot_entry_t;

  typedef struct packed {
    logic              rd_en;
    logic [IdxW-1:0]   rd_addr;
    logic              wr_en;
    logic [IdxW-1:0]   wr_addr;
    slot_entry_t       wr_data;
  } ram_req_t;

endpackage

`default_nettype wire

### src/lpkv_slot_ram.sv
// Slot store of the key/value table: key, address and size per slot.
// One write and one registered read per cycle. Depends on lpkv_pkg.
`default_nettype none

module lpkv_slot_ram (
  input  wire                    clk_i,
  input  lpkv_pkg::ram_req_t     req_i,
  output lpkv_pkg::slot_entry_t  rdata_o
);

  lpkv_pkg::slot_entry_t mem_q [lpkv_pkg::TableDepth];
  lpkv_pkg::slot_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/lpkv_probe_ctrl.sv
// Probe sequencer: walks slots from the start slot, compares, keeps the valid
// bits and the registration count. Depends on lpkv_pkg and the slot store.
`default_nettype none

module lpkv_probe_ctrl (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    start,
  input  lpkv_pkg::lpkv_req_t    req_i,
  output logic                   busy_o,
  output lpkv_pkg::ram_req_t     ram_o,
  input  lpkv_pkg::slot_entry_t  rdata_i,
  output logic                   done_o,
  output lpkv_pkg::lpkv_rsp_t    rsp_o
);

  lpkv_pkg::state_e              state_q, state_d;
  lpkv_pkg::lpkv_req_t           req_q;
  logic [lpkv_pkg::IdxW-1:0]     rd_idx_q, cmp_idx_q, chk_cnt_q;
  logic                          cmp_vld_q;
  logic [lpkv_pkg::TableDepth-1:0] valid_q, valid_d;
  logic [lpkv_pkg::CountW-1:0]   count_q, count_d;
  logic [lpkv_pkg::KeyW-1:0]     key_masked;

  logic slot_valid, key_hit, empty_stop, stop, last, finish;
  lpkv_pkg::op_e op;

  assign op         = lpkv_pkg::op_e'(req_q.operation);
  assign key_masked = req_i.key & lpkv_pkg::KeyMask;
  assign slot_valid = valid_q[cmp_idx_q];
  assign key_hit    = slot_valid && (rdata_i.key == req_q.key);
  assign empty_stop = (op == lpkv_pkg::OpRegister) && !slot_valid;
  assign stop       = cmp_vld_q && (key_hit || empty_stop);
  assign last       = cmp_vld_q && (chk_cnt_q == lpkv_pkg::IdxW'(lpkv_pkg::TableDepth - 1));
  assign finish     = (state_q == lpkv_pkg::StProbe) && (stop || last);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lpkv_pkg::StIdle:  if (start) state_d = lpkv_pkg::StProbe;
      lpkv_pkg::StProbe: if (finish) state_d = lpkv_pkg::StIdle;
      default:           state_d = lpkv_pkg::StIdle;
    endcase
  end

  // outputs
  always_comb begin
    busy_o        = (state_q != lpkv_pkg::StIdle);
    ram_o.rd_en   = (state_q == lpkv_pkg::StProbe);
    ram_o.rd_addr = rd_idx_q;
    ram_o.wr_en   = finish && stop && (op == lpkv_pkg::OpRegister);
    ram_o.wr_addr = cmp_idx_q;
    ram_o.wr_data = '{key: req_q.key, address: req_q.buffer_address,
                      size: req_q.buffer_size};
    done_o        = finish;
  end

  // count, valid bits and result
  always_comb begin
    count_d = count_q;
    valid_d = valid_q;
    rsp_o   = '0;
    rsp_o.status = lpkv_pkg::StatusMiss;
    if (finish) begin
      case (op)
        lpkv_pkg::OpRegister: begin
          if (stop) begin
            valid_d[cmp_idx_q]  = 1'b1;
            if (count_q != lpkv_pkg::CountMax) count_d = count_q + 1'b1;
            rsp_o.status        = lpkv_pkg::StatusOk;
            rsp_o.slot_index    = lpkv_pkg::SlotOutW'(cmp_idx_q);
            rsp_o.region_base   = {req_q.buffer_address[lpkv_pkg::AddrW-1:lpkv_pkg::AlignW],
                                   {lpkv_pkg::AlignW{1'b0}}};
            rsp_o.region_offset = req_q.buffer_address[lpkv_pkg::AlignW-1:0];
            rsp_o.region_size   = req_q.buffer_size;
          end else begin
            rsp_o.status = lpkv_pkg::StatusFull;
          end
        end
        lpkv_pkg::OpDeregister, lpkv_pkg::OpLookup: begin
          if (stop) begin
            if (op == lpkv_pkg::OpDeregister) valid_d[cmp_idx_q] = 1'b0;
            rsp_o.status        = lpkv_pkg::StatusOk;
            rsp_o.slot_index    = lpkv_pkg::SlotOutW'(cmp_idx_q);
            rsp_o.region_base   = {rdata_i.address[lpkv_pkg::AddrW-1:lpkv_pkg::AlignW],
                                   {lpkv_pkg::AlignW{1'b0}}};
            rsp_o.region_offset = rdata_i.address[lpkv_pkg::AlignW-1:0];
            rsp_o.region_size   = rdata_i.size;
          end
          if (op == lpkv_pkg::OpDeregister) begin
            if (count_q != '0) count_d = count_q - 1'b1;
            if (count_q == lpkv_pkg::CountW'(1)) valid_d = '0;
          end
        end
        lpkv_pkg::OpCheck: begin
          if (stop) begin
            rsp_o.status     = lpkv_pkg::StatusOk;
            rsp_o.slot_index = lpkv_pkg::SlotOutW'(cmp_idx_q);
          end
        end
        default: rsp_o.status = lpkv_pkg::StatusMiss;
      endcase
    end
    rsp_o.live_count = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lpkv_pkg::StIdle;
      valid_q   <= '0;
      count_q   <= '0;
      cmp_vld_q <= 1'b0;
      chk_cnt_q <= '0;
      rd_idx_q  <= '0;
      cmp_idx_q <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      count_q <= count_d;
      if (state_q == lpkv_pkg::StIdle) begin
        rd_idx_q  <= lpkv_pkg::IdxW'(key_masked % lpkv_pkg::TableDepth);
        cmp_vld_q <= 1'b0;
        chk_cnt_q <= '0;
      end else begin
        rd_idx_q  <= rd_idx_q + 1'b1;
        cmp_idx_q <= rd_idx_q;
        cmp_vld_q <= 1'b1;
        if (cmp_vld_q) chk_cnt_q <= chk_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == lpkv_pkg::StIdle && start) begin
      req_q           <= req_i;
      req_q.key       <= key_masked;
    end
  end

endmodule

`default_nettype wire

### src/linear_probe_key_value_table.sv
// Top level of the linear-probe key/value table: probe sequencer, slot store
// and result register. Depends on lpkv_pkg, lpkv_slot_ram, lpkv_probe_ctrl.
//
// Usage:
//   A transaction is taken at a rising edge with start high and busy low;
//   req_i carries operation, key, buffer_address and buffer_size. busy stays
//   high until the probe ends. Exactly one result follows each transaction on
//   rsp_o, marked by result_valid_o for one cycle; the receiver takes it then
//   and cannot hold it off.
//   Probing visits one slot per cycle from slot key mod depth, upward with
//   wrap-around, limited by the single read port of the slot store and its
//   registered read. A probe stops at the first slot holding the key (for a
//   register, also at the first empty slot) or after all 64 slots; the
//   sequencer's result then goes through the result register to rsp_o. No
//   new transaction is taken while busy is high; a new transaction may be
//   started in the cycle its predecessor's result is shown.
//   Reset clears all valid bits, the count and the control state at once;
//   stored keys and values need no clearing since only valid slots can match.
`default_nettype none

module linear_probe_key_value_table (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start,
  output logic                 busy,
  input  lpkv_pkg::lpkv_req_t  req_i,
  output logic                 result_valid_o,
  output lpkv_pkg::lpkv_rsp_t  rsp_o
);

  lpkv_pkg::ram_req_t    ram_req;
  lpkv_pkg::slot_entry_t ram_rdata;
  lpkv_pkg::lpkv_rsp_t   rsp_d, rsp_q;
  logic                  done, valid_q;

  lpkv_slot_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  lpkv_probe_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .req_i   (req_i),
    .busy_o  (busy),
    .ram_o   (ram_req),
    .rdata_i (ram_rdata),
    .done_o  (done),
    .rsp_o   (rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      rsp_q <= rsp_d;
    end
  end

  assign result_valid_o = valid_q;
  assign rsp_o          = rsp_q;

endmodule

`default_nettype wire

### src/lpkv_checker.sv
// Port-level checks for the linear-probe key/value table and the bind that
// attaches them to the top level. Depends on lpkv_pkg.
`default_nettype none

module lpkv_checker (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 start,
  input wire                 busy,
  input wire                 result_valid_o,
  input lpkv_pkg::lpkv_rsp_t rsp_o
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy low after an accepted transaction");

  a_no_back_to_back_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("two results in consecutive cycles");

  a_result_not_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result shown while a probe is running");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (rsp_o.status == lpkv_pkg::StatusOk ||
                        rsp_o.status == lpkv_pkg::StatusMiss ||
                        rsp_o.status == lpkv_pkg::StatusFull))
    else $error("undefined status code");

  a_miss_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && rsp_o.status != lpkv_pkg::StatusOk) |->
      (rsp_o.slot_index == '0 && rsp_o.region_base == '0 &&
       rsp_o.region_offset == '0 && rsp_o.region_size == '0))
    else $error("miss or full result carries slot or region data");

endmodule

bind linear_probe_key_value_table lpkv_checker u_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .rsp_o          (rsp_o)
);

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for linear_probe_key_value_table: drives register, deregister,
// lookup and check transactions and compares each result with a behavioral table kept here.
// Depends on lpkv_pkg and the table RTL.
module testbench;
  import lpkv_pkg::*;

  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned PoolSize   = 80;
  localparam int unsigned RandomGoal = 900;

  typedef struct {
    lpkv_req_t   req;
    int unsigned gap;
  } pending_t;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  lpkv_req_t req_i;
  logic      result_valid_o;
  lpkv_rsp_t rsp_o;

  logic             tbl_valid [TableDepth];
  logic [KeyW-1:0]  tbl_key   [TableDepth];
  logic [AddrW-1:0] tbl_addr  [TableDepth];
  logic [AddrW-1:0] tbl_size  [TableDepth];
  int unsigned      reg_count;

  lpkv_rsp_t       rsp_expected_q [$];
  pending_t        pending_q [$];
  logic [KeyW-1:0] key_pool [PoolSize];

  bit          took;
  bit          staged;
  lpkv_req_t   staged_req;
  int unsigned wait_left;
  int unsigned idle_cycles;
  int unsigned mismatches;
  int unsigned items_queued;

  linear_probe_key_value_table uut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .req_i,
    .result_valid_o,
    .rsp_o
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int find_slot(logic [KeyW-1:0] k, bit take_empty);
    int first;
    int idx;
    first = int'(k % TableDepth);
    for (int n = 0; n < int'(TableDepth); n++) begin
      idx = (first + n) % int'(TableDepth);
      if (tbl_valid[idx] && tbl_key[idx] == k) return idx;
      if (take_empty && !tbl_valid[idx]) return idx;
    end
    return -1;
  endfunction

  function automatic lpkv_rsp_t with_region(lpkv_rsp_t rsp, logic [AddrW-1:0] addr,
                                            logic [AddrW-1:0] size);
    lpkv_rsp_t r;
    r = rsp;
    r.region_base   = {addr[AddrW-1:AlignW], {AlignW{1'b0}}};
    r.region_offset = addr[AlignW-1:0];
    r.region_size   = size;
    return r;
  endfunction

  task automatic predict_result(input lpkv_req_t r);
    lpkv_rsp_t       rsp;
    logic [KeyW-1:0] k;
    int              s;
    int unsigned     prior;
    rsp = '0;
    rsp.status = StatusMiss;
    k = r.key & KeyMask;
    case (r.operation)
      OpRegister: begin
        s = find_slot(k, 1'b1);
        if (s < 0) begin
          rsp.status = StatusFull;
        end else begin
          tbl_valid[s] = 1'b1;
          tbl_key[s]   = k;
          tbl_addr[s]  = r.buffer_address;
          tbl_size[s]  = r.buffer_size;
          if (reg_count < CountMax) reg_count++;
          rsp.status     = StatusOk;
          rsp.slot_index = s[SlotOutW-1:0];
          rsp = with_region(rsp, r.buffer_address, r.buffer_size);
        end
      end
      OpDeregister: begin
        prior = reg_count;
        s = find_slot(k, 1'b0);
        if (s >= 0) begin
          tbl_valid[s]   = 1'b0;
          rsp.status     = StatusOk;
          rsp.slot_index = s[SlotOutW-1:0];
          rsp = with_region(rsp, tbl_addr[s], tbl_size[s]);
        end
        if (prior > 0) reg_count = prior - 1;
        if (prior == 1) begin
          foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
        end
      end
      default: begin
        s = find_slot(k, 1'b0);
        if (s >= 0) begin
          rsp.status     = StatusOk;
          rsp.slot_index = s[SlotOutW-1:0];
          if (r.operation == OpLookup) rsp = with_region(rsp, tbl_addr[s], tbl_size[s]);
        end
      end
    endcase
    rsp.live_count = reg_count[CountW-1:0];
    rsp_expected_q.push_back(rsp);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [AddrW-1:0] rand_addr();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return AddrW'(rand64());
    endcase
  endfunction

  function automatic int unsigned pick_gap(bit quiet);
    return quiet ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic logic [KeyW-1:0] pick_key();
    if ($urandom_range(0, 4) == 0) return rand64();
    return key_pool[$urandom_range(0, PoolSize - 1)];
  endfunction

  task automatic queue_request(op_e op, logic [KeyW-1:0] key, logic [AddrW-1:0] addr,
                               logic [AddrW-1:0] size, int unsigned gap);
    pending_t p;
    p.req.operation      = op;
    p.req.key            = key;
    p.req.buffer_address = addr;
    p.req.buffer_size    = size;
    p.gap                = gap;
    pending_q.push_back(p);
    items_queued++;
  endtask

  task automatic wait_quiet();
    while (pending_q.size() != 0 || staged || start || rsp_expected_q.size() != 0)
      @(posedge clk_i);
  endtask

  // driver: hold the transaction until taken, then idle for the next one's gap
  always @(negedge clk_i) begin
    pending_t nxt;
    if (rst_ni && !(start && !took)) begin
      if (!staged && pending_q.size() != 0) begin
        nxt        = pending_q.pop_front();
        staged_req = nxt.req;
        wait_left  = nxt.gap;
        staged     = 1'b1;
      end
      if (staged && wait_left == 0) begin
        req_i  <= staged_req;
        start  <= 1'b1;
        staged  = 1'b0;
      end else begin
        start <= 1'b0;
        if (staged) wait_left--;
      end
    end
  end

  // monitor: check results before predicting a transaction taken at the same edge
  always @(posedge clk_i) begin
    lpkv_rsp_t want;
    if (!rst_ni) begin
      took <= 1'b0;
    end else begin
      took <= start && !busy;
      if (result_valid_o) begin
        if (rsp_expected_q.size() == 0) begin
          mismatches++;
          $error("result with no transaction pending: status %0d", rsp_o.status);
        end else begin
          want = rsp_expected_q.pop_front();
          check_field("status", want.status, rsp_o.status);
          check_field("slot_index", want.slot_index, rsp_o.slot_index);
          check_field("region_base", want.region_base, rsp_o.region_base);
          check_field("region_offset", want.region_offset, rsp_o.region_offset);
          check_field("region_size", want.region_size, rsp_o.region_size);
          check_field("live_count", want.live_count, rsp_o.live_count);
        end
      end
      if (start && !busy) predict_result(req_i);
      if (result_valid_o || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    bit              quiet;
    int unsigned     kind;
    int unsigned     n;
    int unsigned     base;
    logic [KeyW-1:0] k;
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    reg_count = 0;
    foreach (tbl_valid[i]) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i]   = '0;
      tbl_addr[i]  = '0;
      tbl_size[i]  = '0;
    end
    foreach (key_pool[i]) begin
      key_pool[i] = rand64();
      key_pool[i][5:0] = (i % 2) ? 6'(48 + $urandom_range(0, 15)) : 6'($urandom_range(0, 15));
    end

    queue_request(OpLookup, '0, '0, '0, pick_gap(0));
    queue_request(OpDeregister, 64'd5, '1, '1, pick_gap(0));
    queue_request(OpRegister, '0, '0, '0, pick_gap(0));
    queue_request(OpRegister, '1, '1, '1, pick_gap(0));
    queue_request(OpLookup, '1, '0, '0, pick_gap(0));
    queue_request(OpCheck, '1, '1, '1, pick_gap(0));
    queue_request(OpCheck, '0, '0, '0, pick_gap(0));
    queue_request(OpRegister, '0, 48'h1234_5678_9ABC, 48'h0000_0010_0000, pick_gap(0));
    queue_request(OpRegister, 64'd64, rand_addr(), rand_addr(), pick_gap(0));
    queue_request(OpRegister, 64'd128, rand_addr(), rand_addr(), pick_gap(0));
    queue_request(OpDeregister, '0, '0, '0, pick_gap(0));
    queue_request(OpRegister, 64'd128, rand_addr(), rand_addr(), pick_gap(0));
    queue_request(OpLookup, 64'd128, '0, '0, pick_gap(0));
    queue_request(OpDeregister, 64'd128, '0, '0, pick_gap(0));
    queue_request(OpLookup, 64'd128, '0, '0, pick_gap(0));
    queue_request(OpRegister, 64'd63, rand_addr(), rand_addr(), pick_gap(0));
    queue_request(OpRegister, 64'd127, rand_addr(), rand_addr(), pick_gap(0));
    queue_request(OpCheck, 64'd999, '0, '0, pick_gap(0));
    for (int i = 0; i < 8; i++) queue_request(OpDeregister, 64'd999, '0, '0, pick_gap(0));
    queue_request(OpLookup, '1, '0, '0, pick_gap(0));

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait_quiet();
    quiet = ($urandom_range(0, 1) == 0);
    foreach (key_pool[i]) queue_request(OpRegister, key_pool[i], rand_addr(), rand_addr(),
                                        pick_gap(quiet));

    while (items_queued < RandomGoal) begin
      wait_quiet();
      quiet = ($urandom_range(0, 3) == 0);
      kind  = $urandom_range(0, 9);
      if (kind < 2) begin
        base = $urandom_range(0, PoolSize - 1);
        n    = $urandom_range(20, PoolSize);
        for (int i = 0; i < int'(n); i++)
          queue_request(OpRegister, key_pool[(base + i) % PoolSize], rand_addr(), rand_addr(),
                        pick_gap(quiet));
      end else if (kind < 6) begin
        for (int i = 0; i < 40; i++)
          queue_request(op_e'($urandom_range(0, 3)), pick_key(), rand_addr(), rand_addr(),
                        pick_gap(quiet));
      end else if (kind < 8) begin
        n = reg_count + 2;
        for (int i = 0; i < int'(n); i++)
          queue_request(OpDeregister, pick_key(), rand_addr(), rand_addr(), pick_gap(quiet));
      end else begin
        for (int i = 0; i < 10; i++)
          queue_request(op_e'($urandom_range(0, 3)), rand64(), rand_addr(), rand_addr(),
                        pick_gap(quiet));
        k = pick_key();
        queue_request(OpDeregister, k, rand_addr(), rand_addr(), pick_gap(quiet));
        queue_request(OpDeregister, k, rand_addr(), rand_addr(), pick_gap(quiet));
        queue_request(OpLookup, k, rand_addr(), rand_addr(), pick_gap(quiet));
      end
    end

    // empty the table, then overwrite one key repeatedly
    wait_quiet();
    n = reg_count + 1;
    for (int i = 0; i < int'(n); i++)
      queue_request(OpDeregister, pick_key(), rand_addr(), rand_addr(), 0);
    wait_quiet();
    k = key_pool[$urandom_range(0, PoolSize - 1)];
    for (int i = 0; i < 20; i++)
      queue_request(OpRegister, k, rand_addr(), rand_addr(), 0);
    queue_request(OpLookup, k, '0, '0, pick_gap(0));
    queue_request(OpCheck, k, '0, '0, pick_gap(0));
    queue_request(OpDeregister, k, '0, '0, pick_gap(0));
    queue_request(OpLookup, k, '0, '0, pick_gap(0));
    queue_request(OpRegister, k, rand_addr(), rand_addr(), pick_gap(0));

    wait_quiet();
    repeat (80) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
